// File: design/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/putm_pkg.sv
package putm_pkg;

   // element and result widths
   localparam int DATA_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int C_W    = 35;
   // accumulator covers up to sixteen full-scale products
   localparam int ACC_W  = 36;

   // size register
   localparam int          SIZE_W     = 4;
   localparam logic [3:0]  SIZE_RESET = 4'd8;

   // saturation bounds of the result field
   localparam logic signed [ACC_W-1:0] C_MAX = 36'sd17179869183;
   localparam logic signed [ACC_W-1:0] C_MIN = -36'sd17179869184;

   // queue depths
   localparam int LOAD_Q_DEPTH = 2;
   localparam int RES_DEPTH    = 4;

   // back end sequencer states
   typedef enum logic {
      BK_LOAD,
      BK_RUN
   } bk_state_type;

endpackage

// File: design/putm_fifo.sv
module putm_fifo
   import putm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;

   assign full  = (fill_ff == NW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign dout  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: design/putm_front.sv
`include "assert_macros.svh"

module putm_front
   import putm_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [SIZE_W-1:0]                       csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [2*DATA_W-1:0]                     req_tdata,
   input  logic                                    q_full,
   output logic                                    q_push,
   output logic [2*DATA_W+((MAX_N > 1) ? $clog2(MAX_N*(MAX_N+1)/2) : 1):0] q_din,
   output logic [$clog2(MAX_N+1)-1:0]              n_eff
);

   localparam int NW    = $clog2(MAX_N + 1);
   localparam int DEPTH = MAX_N * (MAX_N + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int TW    = 2 * NW + 1;

   logic [SIZE_W-1:0] size_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [TW-1:0]     tri_prod;
   logic [CW-1:0]     total;
   logic              last_item;

   // effective size: zero reads as one, oversize clamps to the maximum
   always_comb begin
      if (size_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(size_ff) > MAX_N) begin
         n_eff = NW'(MAX_N);
      end else begin
         n_eff = NW'(size_ff);
      end
   end

   // element count of the packed triangle
   assign tri_prod = TW'(n_eff) * (TW'(n_eff) + 1'b1);
   assign total    = CW'(tri_prod >> 1);

   // classify the item and hand it to the load queue
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign last_item  = (cnt_ff == total - 1'b1);
   assign q_din      = {last_item, AW'(cnt_ff), req_tdata};

   always_comb begin
      cnt_in = cnt_ff;
      if (csr_we) begin
         cnt_in = '0;
      end else if (q_push) begin
         cnt_in = last_item ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         cnt_ff  <= '0;
      end else begin
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_ALWAYS(a_cnt_in_range, clock, reset, cnt_ff < total, "load count past matrix end")

endmodule

// File: design/putm_back.sv
`include "assert_macros.svh"

module putm_back
   import putm_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_N+1)-1:0]          n_eff,
   input  logic                                q_empty,
   input  logic [2*DATA_W+((MAX_N > 1) ? $clog2(MAX_N*(MAX_N+1)/2) : 1):0] q_dout,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [C_W-1:0]                      rsp_c_value,
   output logic                                rsp_last
);

   localparam int NW    = $clog2(MAX_N + 1);
   localparam int DEPTH = MAX_N * (MAX_N + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CRW   = $clog2(RES_DEPTH + 1);

   typedef struct packed {
      logic first_term;
      logic last_term;
      logic last_elem;
   } step_type;

   bk_state_type state_ff, state_in;

   logic [NW-1:0] r_ff, r_in, c_ff, c_in, e_ff, e_in;
   logic [NW-1:0] n_m1;
   logic [AW-1:0] k_ff, k_in, base_ff, base_in;
   logic [AW-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [CRW-1:0] credit_ff, credit_in;
   logic           issue;
   step_type       step;

   logic signed [DATA_W-1:0] q_a, q_b;
   logic [AW-1:0]            q_addr;
   logic                     q_last;

   logic signed [DATA_W-1:0] a_mem [DEPTH];
   logic signed [DATA_W-1:0] b_mem [DEPTH];

   logic                     v1_ff, v2_ff;
   step_type                 s1_ff, s2_ff;
   logic signed [DATA_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, sum, sat;

   logic           res_push, res_pop, res_full, res_empty;
   logic [C_W:0]   res_dout;

   assign n_m1   = n_eff - 1'b1;
   assign q_a    = q_dout[DATA_W-1:0];
   assign q_b    = q_dout[2*DATA_W-1:DATA_W];
   assign q_addr = q_dout[2*DATA_W+AW-1:2*DATA_W];
   assign q_last = q_dout[2*DATA_W+AW];

   // sequencer: loads the stores, then walks (r, c, e) one product a cycle while result credits allow
   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      e_in      = e_ff;
      k_in      = k_ff;
      base_in   = base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      q_pop     = 1'b0;
      issue     = 1'b0;
      step      = '0;
      case (state_ff)
         BK_LOAD: begin
            q_pop = !q_empty;
            if (q_pop && q_last) begin
               state_in  = BK_RUN;
               r_in      = '0;
               c_in      = '0;
               e_in      = '0;
               k_in      = '0;
               base_in   = '0;
               a_addr_in = '0;
               b_addr_in = '0;
            end
         end
         BK_RUN: begin
            // a new element starts only with room reserved in the result queue
            issue           = (e_ff != r_ff) || (credit_ff < CRW'(RES_DEPTH));
            step.first_term = (e_ff == r_ff);
            step.last_term  = (e_ff == c_ff);
            step.last_elem  = step.last_term && (c_ff == n_m1) && (r_ff == n_m1);
            if (issue) begin
               if (e_ff != c_ff) begin
                  // next term: A moves along the row, B down the column
                  e_in      = e_ff + 1'b1;
                  a_addr_in = a_addr_ff + 1'b1;
                  b_addr_in = b_addr_ff + AW'(n_m1 - e_ff);
               end else if (c_ff != n_m1) begin
                  // next column of the same row
                  c_in      = c_ff + 1'b1;
                  e_in      = r_ff;
                  k_in      = k_ff + 1'b1;
                  a_addr_in = base_ff;
                  b_addr_in = k_ff + 1'b1;
               end else if (r_ff != n_m1) begin
                  // next row starts on its diagonal
                  r_in      = r_ff + 1'b1;
                  c_in      = r_ff + 1'b1;
                  e_in      = r_ff + 1'b1;
                  base_in   = base_ff + AW'(n_eff - r_ff);
                  k_in      = base_ff + AW'(n_eff - r_ff);
                  a_addr_in = base_ff + AW'(n_eff - r_ff);
                  b_addr_in = base_ff + AW'(n_eff - r_ff);
               end else begin
                  state_in = BK_LOAD;
               end
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      c_ff      <= c_in;
      e_ff      <= e_in;
      k_ff      <= k_in;
      base_ff   <= base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   // result credits: elements in flight plus results waiting
   assign res_pop = rsp_tvalid && rsp_tready;

   always_comb begin
      credit_in = credit_ff;
      if (issue && step.first_term) begin
         credit_in = credit_in + 1'b1;
      end
      if (res_pop) begin
         credit_in = credit_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // element stores, registered reads
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_mem[q_addr] <= q_a;
         b_mem[q_addr] <= q_b;
      end
      if (issue) begin
         a_rd_ff <= a_mem[a_addr_ff];
         b_rd_ff <= b_mem[b_addr_ff];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      s1_ff   <= step;
      s2_ff   <= s1_ff;
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   // accumulate and saturate
   always_comb begin
      if (s2_ff.first_term) begin
         sum = ACC_W'(prod_ff);
      end else begin
         sum = acc_ff + ACC_W'(prod_ff);
      end
      if (sum > C_MAX) begin
         sat = C_MAX;
      end else if (sum < C_MIN) begin
         sat = C_MIN;
      end else begin
         sat = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= sum;
      end
   end

   assign res_push = v2_ff && s2_ff.last_term;

   // result queue doubles as the output register
   putm_fifo #(
      .WIDTH (C_W + 1),
      .DEPTH (RES_DEPTH)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   ({s2_ff.last_elem, sat[C_W-1:0]}),
      .pop   (res_pop),
      .dout  (res_dout),
      .full  (res_full),
      .empty (res_empty)
   );

   assign rsp_tvalid  = !res_empty;
   assign rsp_c_value = res_dout[C_W-1:0];
   assign rsp_last    = res_dout[C_W];

   `ASSERT_ALWAYS(a_credit_bound, clock, reset, credit_ff <= CRW'(RES_DEPTH), "credit overrun")
   `ASSERT_IMPLY(a_push_has_room, clock, reset, res_push, !res_full, "result queue overflow")
   `ASSERT_IMPLY(a_no_load_in_run, clock, reset, state_ff == BK_RUN, !q_pop, "store written mid run")
   `ASSERT_NEXT(a_last_ends_run, clock, reset, issue && step.last_elem, state_ff == BK_LOAD, "run outlived last element")

endmodule

// File: design/packed_upper_triangular_matmul.sv
// last item to first result: load queue, stores, read register, product register, result queue
// loads: one item a cycle while the load queue has room; it holds two during a product phase
// product phase: one multiply-accumulate a cycle while result credits allow,
//   n(n+1)(n+2)/6 products per matrix by the single multiplier walking both element stores
// reset (synchronous): size back to 8, load count and queues cleared, stores left as is
module packed_upper_triangular_matmul
   import putm_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // size register
   input  logic                      csr_we,
   input  logic [SIZE_W-1:0]         csr_wdata,
   // input items
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // a_value [15:0], b_value [31:16]
   // result items
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,   // c_value [34:0], zero [39:35]
   output logic                      rsp_tlast    // last_result
);

   localparam int NW    = $clog2(MAX_N + 1);
   localparam int DEPTH = MAX_N * (MAX_N + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW    = 2 * DATA_W + AW + 1;

   logic [NW-1:0]  n_eff;
   logic           q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]  q_din, q_dout;
   logic [C_W-1:0] c_value;

   putm_front #(
      .MAX_N (MAX_N)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_din      (q_din),
      .n_eff      (n_eff)
   );

   // load queue between front and back
   putm_fifo #(
      .WIDTH (QW),
      .DEPTH (LOAD_Q_DEPTH)
   ) u_load_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   putm_back #(
      .MAX_N (MAX_N)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .n_eff       (n_eff),
      .q_empty     (q_empty),
      .q_dout      (q_dout),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_c_value (c_value),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, c_value};

endmodule
